// ----- src/uart_command_frame_decoder_macros.svh -----
// Assertion macros shared by the frame decoder modules.
// Depends on nothing; each macro expects clk_i and rst_ni in the enclosing scope.
`ifndef UART_COMMAND_FRAME_DECODER_MACROS_SVH
`define UART_COMMAND_FRAME_DECODER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define UCFD_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ucfd assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define UCFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ucfd assertion failed");

`endif

// ----- src/ucfd_pkg.sv -----
// Types, codes and constants of the command frame decoder.
// Depends on nothing; used by every module of the decoder.
package ucfd_pkg;

  // Frame layout.
  localparam logic [7:0] FrameHeader = 8'hFF;
  localparam logic [3:0] LastIndex   = 4'd11;
  localparam logic [3:0] FirstPayIdx = 4'd3;

  // Command identifiers.
  localparam logic [7:0] IdMeasure   = 8'h02;
  localparam logic [7:0] IdFrequency = 8'h04;
  localparam logic [7:0] IdGain      = 8'h05;
  localparam logic [7:0] IdRelay     = 8'h06;

  // Highest relay number.
  localparam logic [7:0] RelayCount  = 8'd6;

  typedef enum logic [1:0] {
    STATUS_GOOD         = 2'd0,
    STATUS_BAD_HEADER   = 2'd1,
    STATUS_BAD_CHECKSUM = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ACTION_NONE    = 3'd0,
    ACTION_MEASURE = 3'd1,
    ACTION_SET_FREQ = 3'd2,
    ACTION_SET_GAIN = 3'd3,
    ACTION_RELAY   = 3'd4
  } action_e;

  // Frame snapshot handed from the accumulator to the decoder.
  typedef struct packed {
    logic        last;
    logic        header_good;
    logic        sum_match;
    logic [7:0]  id;
    logic [63:0] payload;
  } frame_t;

  // One decoded result.
  typedef struct packed {
    status_e     status;
    action_e     action;
    logic [7:0]  command_id;
    logic [31:0] frequency_word;
    logic [31:0] waveform_word;
    logic [2:0]  gain_code;
    logic [5:0]  relay_mask;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] code;
  } gain_lookup_t;

  // Maps the listed amplifier gains to their codes; anything else misses.
  function automatic gain_lookup_t gain_to_code(logic [7:0] gain);
    gain_lookup_t r;
    r.hit  = 1'b1;
    r.code = 3'd0;
    unique case (gain)
      8'd1:    r.code = 3'd0;
      8'd2:    r.code = 3'd1;
      8'd4:    r.code = 3'd2;
      8'd5:    r.code = 3'd3;
      8'd8:    r.code = 3'd4;
      8'd10:   r.code = 3'd5;
      8'd16:   r.code = 3'd6;
      8'd32:   r.code = 3'd7;
      default: r.hit  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/ucfd_stream_if.sv -----
// Valid/ready channel interfaces of the command frame decoder.
// Depends on nothing; used by the top level for its byte and result channels.
interface ucfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ucfd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [2:0]  action;
  logic [7:0]  command_id;
  logic [31:0] frequency_word;
  logic [31:0] waveform_word;
  logic [2:0]  gain_code;
  logic [5:0]  relay_mask;

  modport source (output valid, output status, output action, output command_id,
                  output frequency_word, output waveform_word, output gain_code,
                  output relay_mask, input ready);
  modport sink   (input valid, input status, input action, input command_id,
                  input frequency_word, input waveform_word, input gain_code,
                  input relay_mask, output ready);
endinterface

// ----- src/uart_command_frame_decoder.sv -----
// Top level of the command frame decoder: input register, accumulator, decoder,
// result register. Depends on ucfd_pkg, ucfd_stream_if, ucfd_frame_acc, ucfd_decode.
//
// The decoder takes one received byte per cycle and groups the bytes into
// back-to-back 12-byte frames. Every twelfth byte yields one result transaction:
// status (good, bad header, checksum mismatch), the decoded action, the raw id and
// the action's operands; the other bytes yield nothing. A byte is captured in the input
// register, is folded into the frame state when it moves on and, if it is the checksum
// byte, the decoded result is loaded into the result register as it moves on, from
// where it is offered on the result channel. Sustained rate
// is one byte per cycle; the input stalls only when the result register is full
// and not being taken while a checksum byte waits in the input register.
`include "uart_command_frame_decoder_macros.svh"

module uart_command_frame_decoder import ucfd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  ucfd_rx_if.sink    rx_i,
  ucfd_res_if.source res_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       res_vld_q, res_vld_d;
  result_t    res_q;
  result_t    dec;
  frame_t     frame;
  logic       res_free;
  logic       step;
  logic       in_ready;

  // The result slot is free when empty or being drained this cycle.
  assign res_free = !res_vld_q || res_o.ready;
  // A non-final byte always moves on; the checksum byte needs the result slot.
  assign step     = in_vld_q && (!frame.last || res_free);
  assign in_ready = !in_vld_q || step;
  assign rx_i.ready = in_ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready) begin
      in_vld_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  ucfd_frame_acc u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .byte_i  (in_byte_q),
    .frame_o (frame)
  );

  ucfd_decode u_dec (
    .frame_i  (frame),
    .result_o (dec)
  );

  // Result register valid: loaded on a checksum byte, cleared when taken.
  always_comb begin
    res_vld_d = res_vld_q;
    if (res_o.ready) begin
      res_vld_d = 1'b0;
    end
    if (step && frame.last) begin
      res_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && frame.last) begin
      res_q <= dec;
    end
  end

  // Result channel.
  assign res_o.valid          = res_vld_q;
  assign res_o.status         = res_q.status;
  assign res_o.action         = res_q.action;
  assign res_o.command_id     = res_q.command_id;
  assign res_o.frequency_word = res_q.frequency_word;
  assign res_o.waveform_word  = res_q.waveform_word;
  assign res_o.gain_code      = res_q.gain_code;
  assign res_o.relay_mask     = res_q.relay_mask;

  `UCFD_ASSERT_NEXT(a_result_from_last, step && frame.last, res_vld_q)
  `UCFD_ASSERT_IMPLIES(a_bad_no_action, res_vld_q && res_q.status != STATUS_GOOD,
                       res_q.action == ACTION_NONE)
  `UCFD_ASSERT_IMPLIES(a_relay_onehot, res_vld_q && res_q.action == ACTION_RELAY,
                       $onehot(res_q.relay_mask))
  `UCFD_ASSERT_IMPLIES(a_freq_only_set, res_vld_q && res_q.action != ACTION_SET_FREQ,
                       res_q.frequency_word == '0 && res_q.waveform_word == '0)

endmodule

// ----- src/ucfd_frame_acc.sv -----
// Frame accumulator: byte position, running XOR, header flag, id and payload.
// Depends on ucfd_pkg and the assertion macros header.
`include "uart_command_frame_decoder_macros.svh"

module ucfd_frame_acc import ucfd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output frame_t     frame_o
);

  logic [3:0]  cnt_q, cnt_d;
  logic [7:0]  xor_q, xor_d;
  logic        hdr_q, hdr_d;
  logic [7:0]  id_q, id_d;
  logic [63:0] pay_q, pay_d;
  logic        last;

  // A count of eleven or more marks the checksum byte.
  assign last = (cnt_q >= LastIndex);

  // Snapshot seen by the decoder together with the current byte.
  assign frame_o.last        = last;
  assign frame_o.header_good = hdr_q;
  assign frame_o.sum_match   = (xor_q == byte_i);
  assign frame_o.id          = id_q;
  assign frame_o.payload     = pay_q;

  // Next state for one consumed byte.
  always_comb begin
    cnt_d = cnt_q;
    xor_d = xor_q;
    hdr_d = hdr_q;
    id_d  = id_q;
    pay_d = pay_q;
    if (step_i) begin
      if (last) begin
        cnt_d = '0;
        xor_d = '0;
      end else begin
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == '0) begin
          hdr_d = (byte_i == FrameHeader);
          xor_d = byte_i;
        end else begin
          xor_d = xor_q ^ byte_i;
        end
        if (cnt_q == 4'd1) begin
          id_d = byte_i;
        end
        if (cnt_q >= FirstPayIdx) begin
          pay_d = {pay_q[55:0], byte_i};
        end
      end
    end
  end

  // Frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      xor_q <= '0;
      hdr_q <= 1'b0;
      id_q  <= '0;
      pay_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      xor_q <= xor_d;
      hdr_q <= hdr_d;
      id_q  <= id_d;
      pay_q <= pay_d;
    end
  end

  `UCFD_ASSERT_IMPLIES(a_cnt_range, 1'b1, cnt_q <= LastIndex)
  `UCFD_ASSERT_NEXT(a_wrap_after_last, step_i && last, cnt_q == '0 && xor_q == '0)
  `UCFD_ASSERT_NEXT(a_hold_when_idle, !step_i, $stable(cnt_q) && $stable(xor_q))

endmodule

// ----- src/ucfd_decode.sv -----
// Frame decoder: checks header and checksum and maps the id to one action.
// Depends on ucfd_pkg.
module ucfd_decode import ucfd_pkg::*; (
  input  frame_t  frame_i,
  output result_t result_o
);

  logic [7:0]   first;
  gain_lookup_t gain;

  assign first = frame_i.payload[63:56];
  assign gain  = gain_to_code(first);

  // Status first, then the action of a good frame.
  always_comb begin
    result_o                = '0;
    result_o.status         = STATUS_GOOD;
    result_o.action         = ACTION_NONE;
    result_o.command_id     = frame_i.id;
    if (!frame_i.header_good) begin
      result_o.status = STATUS_BAD_HEADER;
    end else if (!frame_i.sum_match) begin
      result_o.status = STATUS_BAD_CHECKSUM;
    end else begin
      unique case (frame_i.id)
        IdMeasure: begin
          result_o.action = ACTION_MEASURE;
        end
        IdFrequency: begin
          result_o.action         = ACTION_SET_FREQ;
          result_o.frequency_word = frame_i.payload[63:32];
          result_o.waveform_word  = frame_i.payload[31:0];
        end
        IdGain: begin
          if (gain.hit) begin
            result_o.action    = ACTION_SET_GAIN;
            result_o.gain_code = gain.code;
          end
        end
        IdRelay: begin
          if (first >= 8'd1 && first <= RelayCount) begin
            result_o.action     = ACTION_RELAY;
            result_o.relay_mask = 6'(6'd1 << 3'(first - 8'd1));
          end
        end
        default: begin
          result_o.action = ACTION_NONE;
        end
      endcase
    end
  end

endmodule

// ----- tb/uart_command_frame_decoder_tb.sv -----
// Testbench for the command frame decoder: directed frames, then random frames.
// Depends on ucfd_pkg, ucfd_stream_if and uart_command_frame_decoder.
// Every result transaction is checked against a hand-written result or a cycle-free frame predictor.
module uart_command_frame_decoder_tb import ucfd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FrameLen     = 12;
  localparam int RandomFrames = 120;
  localparam int QuietFrames  = 20;
  localparam int DrainAt      = 60;
  localparam int CycleLimit   = 200000;

  // Listed amplifier gains, in code order.
  localparam logic [7:0] GainSteps [8] = '{8'd1, 8'd2, 8'd4, 8'd5, 8'd8, 8'd10, 8'd16, 8'd32};

  typedef logic [7:0] frame_bytes_t [FrameLen];

  // One directed frame: header, id, payload bytes 3..10, a checksum fault, and
  // optionally a result written out by hand.
  typedef struct packed {
    logic [7:0]  hdr;
    logic [7:0]  id;
    logic [63:0] payload;
    logic        bad_sum;
    logic        typed;
    result_t     want;
  } frame_row_t;

  localparam result_t NoWant = '0;
  localparam int DirectedRows = 22;
  localparam frame_row_t DirectedFrames [DirectedRows] = '{
    '{8'hFF, IdMeasure, 64'h0, 1'b0, 1'b1,
      '{STATUS_GOOD, ACTION_MEASURE, IdMeasure, 32'h0, 32'h0, 3'd0, 6'd0}},
    '{8'h00, IdMeasure, 64'h0, 1'b0, 1'b1,
      '{STATUS_BAD_HEADER, ACTION_NONE, IdMeasure, 32'h0, 32'h0, 3'd0, 6'd0}},
    '{8'hFE, IdFrequency, '1, 1'b0, 1'b1,
      '{STATUS_BAD_HEADER, ACTION_NONE, IdFrequency, 32'h0, 32'h0, 3'd0, 6'd0}},
    '{8'hFF, IdFrequency, 64'h1122334455667788, 1'b1, 1'b1,
      '{STATUS_BAD_CHECKSUM, ACTION_NONE, IdFrequency, 32'h0, 32'h0, 3'd0, 6'd0}},
    '{8'h7F, IdGain, 64'h0400000000000000, 1'b1, 1'b1,
      '{STATUS_BAD_HEADER, ACTION_NONE, IdGain, 32'h0, 32'h0, 3'd0, 6'd0}},
    '{8'hFF, IdFrequency, '1, 1'b0, 1'b1,
      '{STATUS_GOOD, ACTION_SET_FREQ, IdFrequency, '1, '1, 3'd0, 6'd0}},
    '{8'hFF, IdFrequency, 64'h0, 1'b0, 1'b1,
      '{STATUS_GOOD, ACTION_SET_FREQ, IdFrequency, 32'h0, 32'h0, 3'd0, 6'd0}},
    '{8'hFF, IdFrequency, 64'h0123456789ABCDEF, 1'b0, 1'b0, NoWant},
    '{8'hFF, IdGain, 64'h01A5A5A5A5A5A5A5, 1'b0, 1'b1,
      '{STATUS_GOOD, ACTION_SET_GAIN, IdGain, 32'h0, 32'h0, 3'd0, 6'd0}},
    '{8'hFF, IdGain, 64'h2000000000000000, 1'b0, 1'b1,
      '{STATUS_GOOD, ACTION_SET_GAIN, IdGain, 32'h0, 32'h0, 3'd7, 6'd0}},
    '{8'hFF, IdGain, 64'h0, 1'b0, 1'b1,
      '{STATUS_GOOD, ACTION_NONE, IdGain, 32'h0, 32'h0, 3'd0, 6'd0}},
    '{8'hFF, IdGain, 64'h0A00000000000000, 1'b0, 1'b0, NoWant},
    '{8'hFF, IdGain, 64'h0300000000000000, 1'b0, 1'b0, NoWant},
    '{8'hFF, IdGain, '1, 1'b0, 1'b0, NoWant},
    '{8'hFF, IdRelay, 64'h0100000000000000, 1'b0, 1'b1,
      '{STATUS_GOOD, ACTION_RELAY, IdRelay, 32'h0, 32'h0, 3'd0, 6'h01}},
    '{8'hFF, IdRelay, 64'h06FFFFFFFFFFFFFF, 1'b0, 1'b1,
      '{STATUS_GOOD, ACTION_RELAY, IdRelay, 32'h0, 32'h0, 3'd0, 6'h20}},
    '{8'hFF, IdRelay, 64'h0, 1'b0, 1'b0, NoWant},
    '{8'hFF, IdRelay, 64'h0700000000000000, 1'b0, 1'b0, NoWant},
    '{8'hFF, IdRelay, 64'h0312345678123456, 1'b0, 1'b0, NoWant},
    '{8'hFF, 8'h00, 64'h0102030405060708, 1'b0, 1'b0, NoWant},
    '{8'hFF, 8'hFF, '1, 1'b0, 1'b0, NoWant},
    '{8'hFF, 8'h03, 64'h0400000000000000, 1'b0, 1'b0, NoWant}
  };

  logic clk_i;
  logic rst_ni;

  ucfd_rx_if  rx_ch ();
  ucfd_res_if res_ch ();

  uart_command_frame_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_ch),
    .res_o  (res_ch)
  );

  // Frame predictor state.
  logic [3:0]  frm_pos;
  logic [7:0]  frm_xor;
  logic        frm_hdr_ok;
  logic [7:0]  frm_id;
  logic [63:0] frm_payload;

  result_t pending_results [$];
  int      error_count;
  int      cycle_count;
  bit      idle_enable;
  int      ready_stall;

  // Clock.
  always #2 clk_i = ~clk_i;

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL uart_command_frame_decoder");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Folds one byte into the predicted frame state; returns 1 with the decoded
  // result when the byte closes the frame.
  function automatic logic decode_frame_byte(input logic [7:0] b, output result_t r);
    logic [7:0] lead;
    r = '0;
    if (frm_pos < LastIndex) begin
      if (frm_pos == 4'd0) begin
        frm_hdr_ok = (b == FrameHeader);
        frm_xor    = b;
      end else begin
        frm_xor = frm_xor ^ b;
      end
      if (frm_pos == 4'd1) frm_id = b;
      if (frm_pos >= FirstPayIdx) frm_payload = {frm_payload[55:0], b};
      frm_pos = frm_pos + 4'd1;
      return 1'b0;
    end

    // Checksum byte: judge the frame and decode the command.
    lead         = frm_payload[63:56];
    r.command_id = frm_id;
    if (!frm_hdr_ok) begin
      r.status = STATUS_BAD_HEADER;
    end else if (frm_xor != b) begin
      r.status = STATUS_BAD_CHECKSUM;
    end else begin
      r.status = STATUS_GOOD;
      case (frm_id)
        IdMeasure: r.action = ACTION_MEASURE;
        IdFrequency: begin
          r.action         = ACTION_SET_FREQ;
          r.frequency_word = frm_payload[63:32];
          r.waveform_word  = frm_payload[31:0];
        end
        IdGain: begin
          for (int k = 0; k < 8; k++) begin
            if (GainSteps[k] == lead) begin
              r.action    = ACTION_SET_GAIN;
              r.gain_code = 3'(k);
            end
          end
        end
        IdRelay: begin
          if (lead >= 8'd1 && lead <= RelayCount) begin
            r.action     = ACTION_RELAY;
            r.relay_mask = 6'(1 << (lead - 8'd1));
          end
        end
        default: ;
      endcase
    end
    frm_pos = 4'd0;
    frm_xor = 8'd0;
    return 1'b1;
  endfunction

  function automatic frame_bytes_t build_frame(input logic [7:0] hdr, input logic [7:0] id,
                                               input logic [63:0] payload,
                                               input logic bad_sum);
    frame_bytes_t f;
    logic [7:0]   sum;
    f[0] = hdr;
    f[1] = id;
    f[2] = 8'($urandom);
    for (int i = 0; i < 8; i++) f[3 + i] = payload[63 - 8 * i -: 8];
    sum = 8'd0;
    for (int i = 0; i < FrameLen - 1; i++) sum ^= f[i];
    f[FrameLen - 1] = bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum;
    return f;
  endfunction

  task automatic idle_sender(input int cycles);
    rx_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // Sends one byte and, once the transaction is taken, records what it should yield.
  task automatic send_byte(input logic [7:0] b, input logic typed, input result_t want);
    result_t r;
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk_i); while (rx_ch.ready !== 1'b1);
    if (decode_frame_byte(b, r)) pending_results.push_back(typed ? want : r);
  endtask

  task automatic send_frame(input frame_bytes_t f, input logic typed, input result_t want,
                            input bit gaps);
    for (int i = 0; i < FrameLen; i++) begin
      if (gaps && idle_enable && $urandom_range(0, 7) == 0)
        idle_sender($urandom_range(1, 3));
      send_byte(f[i], typed, want);
    end
  endtask

  // Random frame: mostly well-formed commands, some bad headers, bad sums and odd ids.
  function automatic frame_bytes_t random_frame();
    logic [7:0]  hdr;
    logic [7:0]  id;
    logic [63:0] payload;
    hdr     = ($urandom_range(0, 99) < 10) ? 8'($urandom) : FrameHeader;
    payload = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: id = IdMeasure;
      1: id = IdFrequency;
      2: id = IdGain;
      3: id = IdRelay;
      default: id = 8'($urandom);
    endcase
    if (id == IdGain && $urandom_range(0, 3) != 0)
      payload[63:56] = GainSteps[$urandom_range(0, 7)];
    if (id == IdRelay && $urandom_range(0, 3) != 0)
      payload[63:56] = 8'($urandom_range(0, 7));
    return build_frame(hdr, id, payload, $urandom_range(0, 99) < 12);
  endfunction

  // Result side: random stall bursts while idling is on.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else if (ready_stall > 0) begin
      res_ch.ready <= 1'b0;
      ready_stall  <= ready_stall - 1;
    end else if (idle_enable && $urandom_range(0, 5) == 0) begin
      res_ch.ready <= 1'b0;
      ready_stall  <= $urandom_range(0, 2);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with no result pending");
      end else begin
        want = pending_results.pop_front();
        if (res_ch.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", res_ch.status, want.status));
        if (res_ch.action !== want.action)
          report_mismatch($sformatf("action got %0d want %0d", res_ch.action, want.action));
        if (res_ch.command_id !== want.command_id)
          report_mismatch($sformatf("command_id got %h want %h",
                                    res_ch.command_id, want.command_id));
        if (res_ch.frequency_word !== want.frequency_word)
          report_mismatch($sformatf("frequency_word got %h want %h",
                                    res_ch.frequency_word, want.frequency_word));
        if (res_ch.waveform_word !== want.waveform_word)
          report_mismatch($sformatf("waveform_word got %h want %h",
                                    res_ch.waveform_word, want.waveform_word));
        if (res_ch.gain_code !== want.gain_code)
          report_mismatch($sformatf("gain_code got %0d want %0d",
                                    res_ch.gain_code, want.gain_code));
        if (res_ch.relay_mask !== want.relay_mask)
          report_mismatch($sformatf("relay_mask got %b want %b",
                                    res_ch.relay_mask, want.relay_mask));
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'd0;
    res_ch.ready  = 1'b0;
    frm_pos       = 4'd0;
    frm_xor       = 8'd0;
    frm_hdr_ok    = 1'b0;
    frm_id        = 8'd0;
    frm_payload   = 64'd0;
    error_count   = 0;
    cycle_count   = 0;
    ready_stall   = 0;
    idle_enable   = 1'b1;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames from the table.
    foreach (DirectedFrames[i]) begin
      send_frame(build_frame(DirectedFrames[i].hdr, DirectedFrames[i].id,
                             DirectedFrames[i].payload, DirectedFrames[i].bad_sum),
                 DirectedFrames[i].typed, DirectedFrames[i].want, 1'b1);
    end

    // Random frames; one pause drains the results, the tail runs without idling.
    for (int n = 0; n < RandomFrames; n++) begin
      if (n == DrainAt) begin
        rx_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk_i);
      end
      if (n == RandomFrames - QuietFrames) idle_enable = 1'b0;
      send_frame(random_frame(), 1'b0, NoWant, $urandom_range(0, 3) != 0);
    end

    rx_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (error_count == 0) begin
      $display("PASS uart_command_frame_decoder");
    end else begin
      $display("FAIL uart_command_frame_decoder");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/ucfd_pkg.sv
src/ucfd_stream_if.sv
src/ucfd_frame_acc.sv
src/ucfd_decode.sv
src/uart_command_frame_decoder.sv
tb/uart_command_frame_decoder_tb.sv
